@@ src/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  localparam int unsigned FieldW      = 16;
  localparam int unsigned OutW        = 40;
  localparam int unsigned CoefWidthDef = 16;
  localparam int unsigned FracBitsDef  = 16;

  typedef enum logic [1:0] {
    KIND_REAL  = 2'd0,
    KIND_CPLX  = 2'd1,
    KIND_LIN   = 2'd2,
    KIND_DEGEN = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [FieldW-1:0] coef_a;
    logic signed [FieldW-1:0] coef_b;
    logic signed [FieldW-1:0] coef_c;
  } in_t;

  typedef struct packed {
    kind_e                  root_kind;
    logic signed [OutW-1:0] root_one;
    logic signed [OutW-1:0] root_two;
  } out_t;

endpackage

@@ src/quadratic_root_solver.sv @@
// Top level: pipelined quadratic root solver built from sqrt and divider cells.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one coefficient set
// a, b, c per transfer. Output channel (out_valid_o/out_ready_i/out_data_o)
// gives root_kind and two Q(40-FRAC_BITS).FRAC_BITS roots per transfer.
// Throughput: one transfer per cycle in both directions, sustained while out_ready_i is high.
// Stages from input transfer to out_valid_o, with CW = min(COEF_WIDTH, 16):
// 2 front stages (products, discriminant), CW+1 square root cells
// (one root bit each), one numerator/denominator stage, CW+2+FRAC_BITS
// divider cells (one quotient bit each, two lanes) and the output register.
// Each stage has its own valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles close up and a stalled receiver only
// holds back items once every stage behind the output is full.
// Reset clears all valid bits; the datapath holds no reset state.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::CoefWidthDef,
  parameter int unsigned FRAC_BITS  = qrs_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qrs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qrs_pkg::out_t out_data_o
);

  localparam int unsigned CW   = (COEF_WIDTH < qrs_pkg::FieldW) ? COEF_WIDTH
                                                                 : qrs_pkg::FieldW;
  localparam int unsigned SN   = CW + 1;          // root bits
  localparam int unsigned DSW  = 2 * CW + 3;      // signed discriminant
  localparam int unsigned NXW  = CW + 3;          // signed numerator/denominator
  localparam int unsigned NW   = CW + 2;          // numerator magnitude
  localparam int unsigned DW   = CW + 1;          // denominator magnitude
  localparam int unsigned QW   = NW + FRAC_BITS;  // quotient bits
  localparam int unsigned OW   = qrs_pkg::OutW;
  localparam int unsigned EW   = (QW > OW) ? QW + 1 : OW + 1;
  localparam int unsigned L    = SN + QW + 4;     // stages incl. output reg
  localparam int unsigned SPRP = SN + 2;          // numerator/denominator stage

  // ---------------- stage flow control ----------------
  logic [L-1:0] vld_q;
  logic [L-1:0] go;

  always_comb begin
    go[L-1] = !vld_q[L-1] || out_ready_i;
    for (int k = L - 2; k >= 0; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < L; k++) begin
        if (go[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = go[0];

  // ---------------- stage 0: sign extend, products ----------------
  logic signed [CW-1:0]   a_in, b_in, c_in;
  logic signed [CW-1:0]   a0_q, b0_q, c0_q;
  logic signed [2*CW-1:0] bb0_q, ac0_q;

  assign a_in = $signed(in_data_i.coef_a[CW-1:0]);
  assign b_in = $signed(in_data_i.coef_b[CW-1:0]);
  assign c_in = $signed(in_data_i.coef_c[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      a0_q  <= a_in;
      b0_q  <= b_in;
      c0_q  <= c_in;
      bb0_q <= (2*CW)'(b_in) * (2*CW)'(b_in);
      ac0_q <= (2*CW)'(a_in) * (2*CW)'(c_in);
    end
  end

  // ---------------- stage 1: discriminant, kind ----------------
  logic signed [DSW-1:0] disc;
  logic signed [DSW-1:0] disc_abs;
  qrs_pkg::kind_e        kind1;

  assign disc     = $signed({{3{bb0_q[2*CW-1]}}, bb0_q})
                  - $signed({ac0_q[2*CW-1], ac0_q, 2'b00});
  assign disc_abs = disc[DSW-1] ? -disc : disc;

  always_comb begin
    priority if (a0_q != '0) begin
      kind1 = disc[DSW-1] ? qrs_pkg::KIND_CPLX : qrs_pkg::KIND_REAL;
    end else if (b0_q != '0) begin
      kind1 = qrs_pkg::KIND_LIN;
    end else begin
      kind1 = qrs_pkg::KIND_DEGEN;
    end
  end

  // sideband through the square root chain; index 0 is stage 1
  logic signed [CW-1:0] sa_q [SN+1];
  logic signed [CW-1:0] sb_q [SN+1];
  logic signed [CW-1:0] sc_q [SN+1];
  qrs_pkg::kind_e       sk_q [SN+1];
  logic [SN:0]          sq_rem  [SN+1];
  logic [SN-1:0]        sq_root [SN+1];
  logic [2*SN-1:0]      sq_rad  [SN+1];
  logic [2*SN-1:0]      rad1_q;

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      sa_q[0] <= a0_q;
      sb_q[0] <= b0_q;
      sc_q[0] <= c0_q;
      sk_q[0] <= kind1;
      rad1_q  <= disc_abs[2*SN-1:0];
    end
    for (int j = 1; j <= SN; j++) begin
      if (go[1+j]) begin
        sa_q[j] <= sa_q[j-1];
        sb_q[j] <= sb_q[j-1];
        sc_q[j] <= sc_q[j-1];
        sk_q[j] <= sk_q[j-1];
      end
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = rad1_q;

  for (genvar j = 0; j < SN; j++) begin : g_sqrt
    qrs_sqrt_cell #(.SN(SN)) u_cell (
      .clk_i  (clk_i),
      .en_i   (go[2+j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .rad_i  (sq_rad[j]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .rad_o  (sq_rad[j+1])
    );
  end

  // ---------------- numerators and denominators ----------------
  logic signed [NXW-1:0] ax2, bx, cx, sx;
  logic signed [NXW-1:0] n1, n2, d1, d2;
  logic                  cplx;

  assign ax2  = $signed({sa_q[SN][CW-1], sa_q[SN][CW-1], sa_q[SN], 1'b0});
  assign bx   = $signed({{3{sb_q[SN][CW-1]}}, sb_q[SN]});
  assign cx   = $signed({{3{sc_q[SN][CW-1]}}, sc_q[SN]});
  assign sx   = $signed({2'b00, sq_root[SN]});
  assign cplx = (sk_q[SN] == qrs_pkg::KIND_CPLX);

  always_comb begin
    unique case (sk_q[SN])
      qrs_pkg::KIND_REAL: begin
        n1 = -bx + sx;  d1 = ax2;
        n2 = -bx - sx;  d2 = ax2;
      end
      qrs_pkg::KIND_CPLX: begin
        // imaginary part uses |2a|; its sign is forced positive below
        n1 = -bx;       d1 = ax2;
        n2 = sx;        d2 = ax2;
      end
      qrs_pkg::KIND_LIN: begin
        n1 = -cx;       d1 = bx;
        n2 = '0;        d2 = NXW'(1);
      end
      default: begin
        n1 = '0;        d1 = NXW'(1);
        n2 = '0;        d2 = NXW'(1);
      end
    endcase
  end

  logic [NXW-1:0] n1m, n2m, d1m, d2m;
  assign n1m = n1[NXW-1] ? -n1 : n1;
  assign n2m = n2[NXW-1] ? -n2 : n2;
  assign d1m = d1[NXW-1] ? -d1 : d1;
  assign d2m = d2[NXW-1] ? -d2 : d2;

  // divider chain; index 0 is the numerator/denominator stage
  logic [DW-1:0]  r1 [QW+1];
  logic [QW-1:0]  q1 [QW+1];
  logic [DW-1:0]  e1 [QW+1];
  logic [DW-1:0]  r2 [QW+1];
  logic [QW-1:0]  q2 [QW+1];
  logic [DW-1:0]  e2 [QW+1];
  logic           ng1_q [QW+1];
  logic           ng2_q [QW+1];
  qrs_pkg::kind_e dk_q  [QW+1];
  logic [QW-1:0]  dvd1_q, dvd2_q;
  logic [DW-1:0]  den1_q, den2_q;

  always_ff @(posedge clk_i) begin
    if (go[SPRP]) begin
      dvd1_q   <= {n1m[NW-1:0], {FRAC_BITS{1'b0}}};
      dvd2_q   <= {n2m[NW-1:0], {FRAC_BITS{1'b0}}};
      den1_q   <= d1m[DW-1:0];
      den2_q   <= d2m[DW-1:0];
      ng1_q[0] <= n1[NXW-1] ^ d1[NXW-1];
      ng2_q[0] <= cplx ? 1'b0 : (n2[NXW-1] ^ d2[NXW-1]);
      dk_q[0]  <= sk_q[SN];
    end
    for (int j = 1; j <= QW; j++) begin
      if (go[SPRP+j]) begin
        ng1_q[j] <= ng1_q[j-1];
        ng2_q[j] <= ng2_q[j-1];
        dk_q[j]  <= dk_q[j-1];
      end
    end
  end

  assign r1[0] = '0;
  assign q1[0] = dvd1_q;
  assign e1[0] = den1_q;
  assign r2[0] = '0;
  assign q2[0] = dvd2_q;
  assign e2[0] = den2_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    qrs_div_cell #(.DW(DW), .QW(QW)) u_lane_one (
      .clk_i (clk_i),
      .en_i  (go[SPRP+1+j]),
      .rem_i (r1[j]),
      .dvd_i (q1[j]),
      .den_i (e1[j]),
      .rem_o (r1[j+1]),
      .dvd_o (q1[j+1]),
      .den_o (e1[j+1])
    );
    qrs_div_cell #(.DW(DW), .QW(QW)) u_lane_two (
      .clk_i (clk_i),
      .en_i  (go[SPRP+1+j]),
      .rem_i (r2[j]),
      .dvd_i (q2[j]),
      .den_i (e2[j]),
      .rem_o (r2[j+1]),
      .dvd_o (q2[j+1]),
      .den_o (e2[j+1])
    );
  end

  // ---------------- sign and saturation, output register ----------------
  function automatic logic signed [OW-1:0] fx_sat(input logic [QW-1:0] q,
                                                  input logic          neg);
    logic [EW-1:0] ext;
    logic [EW-1:0] lim;
    logic [EW-1:0] neg_v;
    ext   = EW'(q);
    lim   = EW'({(OW-1){1'b1}});
    neg_v = -ext;
    if (neg) begin
      fx_sat = (ext > lim + EW'(1)) ? $signed({1'b1, {(OW-1){1'b0}}})
                                     : $signed(neg_v[OW-1:0]);
    end else begin
      fx_sat = (ext > lim) ? $signed({1'b0, {(OW-1){1'b1}}})
                           : $signed(ext[OW-1:0]);
    end
  endfunction

  qrs_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (go[L-1]) begin
      out_q.root_kind <= dk_q[QW];
      out_q.root_one  <= fx_sat(q1[QW], ng1_q[QW]);
      out_q.root_two  <= fx_sat(q2[QW], ng2_q[QW]);
    end
  end

  assign out_valid_o = vld_q[L-1];
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind == qrs_pkg::KIND_DEGEN |->
      out_data_o.root_one == '0 && out_data_o.root_two == '0)
    else $error("degenerate result with nonzero roots");

  a_lin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind == qrs_pkg::KIND_LIN |->
      out_data_o.root_two == '0)
    else $error("linear result with nonzero second root");

  a_cplx_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_kind == qrs_pkg::KIND_CPLX |->
      !out_data_o.root_two[OW-1])
    else $error("negative imaginary magnitude");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> vld_q[0] && out_valid_o && !out_ready_i)
    else $error("input stalled while pipeline not full");

endmodule

@@ src/qrs_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
module qrs_sqrt_cell #(
  parameter int unsigned SN = 17
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SN:0]     rem_i,
  input  logic [SN-1:0]   root_i,
  input  logic [2*SN-1:0] rad_i,
  output logic [SN:0]     rem_o,
  output logic [SN-1:0]   root_o,
  output logic [2*SN-1:0] rad_o
);

  logic [SN+2:0] rem_sh;
  logic [SN+2:0] trial;
  logic [SN+2:0] diff;
  logic          ge;

  assign rem_sh = {rem_i, rad_i[2*SN-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[SN:0] : rem_sh[SN:0];
      root_o <= {root_i[SN-2:0], ge};
      rad_o  <= {rad_i[2*SN-3:0], 2'b00};
    end
  end

endmodule

@@ src/qrs_div_cell.sv @@
// One quotient bit of the pipelined restoring divider.
module qrs_div_cell #(
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] dvd_o,
  output logic [DW-1:0] den_o
);

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  assign rem_sh = {rem_i, dvd_i[QW-1]};
  assign ge     = (rem_sh >= {1'b0, den_i});
  assign diff   = rem_sh - {1'b0, den_i};

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      dvd_o <= {dvd_i[QW-2:0], ge};
      den_o <= den_i;
    end
  end

endmodule
